@@ rtl/u2u_pkg.sv @@
package u2u_pkg;

  localparam logic [15:0] HighFirst = 16'hD800;
  localparam logic [15:0] HighLast  = 16'hDBFF;
  localparam logic [15:0] LowFirst  = 16'hDC00;
  localparam logic [15:0] LowLast   = 16'hDFFF;

  localparam logic [20:0] Lim1Byte  = 21'h00080;
  localparam logic [20:0] Lim2Byte  = 21'h00800;
  localparam logic [20:0] Lim3Byte  = 21'h10000;

  localparam logic [7:0] ContMark   = 8'h80;
  localparam logic [7:0] Lead2Mark  = 8'hC0;
  localparam logic [7:0] Lead3Mark  = 8'hE0;
  localparam logic [7:0] Lead4Mark  = 8'hF0;
  localparam logic [5:0] ContMask   = 6'h3F;

  // supplementary plane offset (0x10000) as it sits above the ten low bits
  localparam logic [10:0] SuppBase  = 11'd64;

  localparam int MaxBytes   = 6;
  localparam int QueueDepth = 2;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } enc_t;

  // one queue entry: every byte caused by one input item
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               len;
    logic                     last;
  } job_t;

  function automatic enc_t encode_point(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < Lim1Byte) begin
      e.bytes[0] = cp[7:0];
      e.len      = 3'd1;
    end else if (cp < Lim2Byte) begin
      e.bytes[0] = Lead2Mark | {3'b000, cp[10:6]};
      e.bytes[1] = ContMark  | {2'b00, cp[5:0] & ContMask};
      e.len      = 3'd2;
    end else if (cp < Lim3Byte) begin
      e.bytes[0] = Lead3Mark | {4'b0000, cp[15:12]};
      e.bytes[1] = ContMark  | {2'b00, cp[11:6] & ContMask};
      e.bytes[2] = ContMark  | {2'b00, cp[5:0] & ContMask};
      e.len      = 3'd3;
    end else begin
      e.bytes[0] = Lead4Mark | {5'b00000, cp[20:18]};
      e.bytes[1] = ContMark  | {2'b00, cp[17:12] & ContMask};
      e.bytes[2] = ContMark  | {2'b00, cp[11:6] & ContMask};
      e.bytes[3] = ContMark  | {2'b00, cp[5:0] & ContMask};
      e.len      = 3'd4;
    end
    return e;
  endfunction

endpackage

@@ rtl/u2u_front.sv @@
module u2u_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [15:0]   code_unit,
  input  logic          last_unit,
  output logic          job_push,
  output u2u_pkg::job_t job
);
  import u2u_pkg::*;

  logic       held_valid_r, held_valid_nxt;
  logic [9:0] held_bits_r, held_bits_nxt;
  logic       term_r, term_nxt;

  logic       is_high, is_low;
  logic       flush_en, point_en;
  logic [20:0] point;
  enc_t       flush_enc, point_enc;

  assign is_high = (code_unit >= HighFirst) && (code_unit <= HighLast);
  assign is_low  = (code_unit >= LowFirst)  && (code_unit <= LowLast);

  always_comb begin
    held_valid_nxt = held_valid_r;
    held_bits_nxt  = held_bits_r;
    term_nxt       = term_r;
    flush_en       = 1'b0;
    point_en       = 1'b0;
    point          = {5'd0, code_unit};
    if (!term_r) begin
      if (held_valid_r && is_low) begin
        point_en       = 1'b1;
        point          = {(SuppBase + {1'b0, held_bits_r}), code_unit[9:0]};
        held_valid_nxt = 1'b0;
        held_bits_nxt  = '0;
      end else begin
        if (held_valid_r) begin
          flush_en       = 1'b1;
          held_valid_nxt = 1'b0;
          held_bits_nxt  = '0;
        end
        if (is_high && !last_unit) begin
          held_valid_nxt = 1'b1;
          held_bits_nxt  = code_unit[9:0];
        end else if (code_unit == 16'd0) begin
          term_nxt = 1'b1;
        end else begin
          point_en = 1'b1;
        end
      end
    end
    // a string end returns everything to reset
    if (last_unit) begin
      held_valid_nxt = 1'b0;
      held_bits_nxt  = '0;
      term_nxt       = 1'b0;
    end
  end

  assign flush_enc = encode_point({5'd0, HighFirst[15:10], held_bits_r});
  assign point_enc = encode_point(point);

  always_comb begin
    job       = '0;
    job.last  = last_unit;
    if (flush_en) begin
      job.bytes[2:0] = flush_enc.bytes[2:0];
      if (point_en) begin
        job.bytes[5:3] = point_enc.bytes[2:0];
        job.len        = 3'd3 + point_enc.len;
      end else begin
        job.len = 3'd3;
      end
    end else if (point_en) begin
      job.bytes[3:0] = point_enc.bytes;
      job.len        = point_enc.len;
    end
  end

  // drop items that cause nothing and do not end the string
  assign job_push = accept && ((job.len != 3'd0) || last_unit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_bits_r  <= '0;
      term_r       <= 1'b0;
    end else if (accept) begin
      held_valid_r <= held_valid_nxt;
      held_bits_r  <= held_bits_nxt;
      term_r       <= term_nxt;
    end
  end

endmodule

@@ rtl/u2u_queue.sv @@
module u2u_queue #(
  parameter int DEPTH = u2u_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  u2u_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output u2u_pkg::job_t rd_job,
  output logic          empty
);
  import u2u_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  job_t            mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            do_wr, do_rd;

  assign full   = (count_r == CntFull);
  assign empty  = (count_r == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PtrMax) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PtrMax) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/u2u_back.sv @@
module u2u_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  u2u_pkg::job_t q_job,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_byte,
  output logic          out_byte_valid,
  output logic          out_run_end,
  output logic          out_string_done
);
  import u2u_pkg::*;

  logic       cur_valid_r;
  job_t       cur_r;
  logic [2:0] idx_r;
  logic       take, load;

  assign empty           = !cur_valid_r;
  assign out_byte_valid  = (cur_r.len != 3'd0);
  assign out_byte        = out_byte_valid ? cur_r.bytes[idx_r] : 8'd0;
  assign out_run_end     = !out_byte_valid || (idx_r == cur_r.len - 3'd1);
  assign out_string_done = out_run_end && cur_r.last;

  assign take  = pop && cur_valid_r;
  // refill when idle or as the final beat of the current job leaves
  assign load  = !cur_valid_r || (take && out_run_end);
  assign q_pop = load && !q_empty;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      cur_valid_r <= !q_empty;
      idx_r       <= '0;
    end else if (take) begin
      idx_r <= idx_r + 3'd1;
    end
  end

endmodule

@@ rtl/utf16_to_utf8_transcoder.sv @@
// A unit accepted is written into the job queue and then loaded into the output
// stage before its first byte shows. Output: one beat per cycle while pop is
// held and no empty queue is awaited; a unit causes zero to six bytes, one a beat.
// The front accepts a unit every cycle while the job queue has room.
// Reset (rst_n low, synchronous) clears the surrogate hold, the string state,
// the job queue and the output stage.
module utf16_to_utf8_transcoder #(
  parameter int QUEUE_DEPTH = u2u_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [15:0] in_code_unit,
  input  logic        in_last_unit,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_run_end,
  output logic        out_string_done
);
  import u2u_pkg::*;

  logic accept;
  logic job_push, q_full, q_pop, q_empty;
  job_t front_job, q_job;

  assign full   = q_full;
  assign accept = push && !q_full;

  u2u_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .code_unit (in_code_unit),
    .last_unit (in_last_unit),
    .job_push  (job_push),
    .job       (front_job)
  );

  u2u_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (job_push),
    .wr_job (front_job),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_job (q_job),
    .empty  (q_empty)
  );

  u2u_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_job           (q_job),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_run_end     (out_run_end),
    .out_string_done (out_string_done)
  );

endmodule
